FILE: hdl/bzf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzf_pkg: shared types and constants of the cubic Bezier flattener
// Holds the operand word of the shared multiply-accumulate unit, the point
// type that the evaluator returns and the fixed Q1.16 constants.
// ----------------------------------------------------------------------------
package bzf_pkg;

	localparam int CHUNK_W = 16;
	localparam int WGT_W   = 17;
	localparam int ACC_W   = 64;
	localparam int T_W     = 17;

	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	typedef logic [3:0][15:0] axis_pts_t;

	typedef struct packed {
		logic               vld;
		logic               clr;
		logic [1:0]         shift;
		logic [CHUNK_W-1:0] chunk;
		logic [WGT_W-1:0]   wgt;
	} mac_op_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} point_t;

endpackage

FILE: hdl/bzf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzf_div: radix-2 restoring divider for the Q1.16 step
// Divides 1.0 (65536) by the segment count one quotient bit per cycle and
// returns quotient and remainder, which then stay stable until restarted.
// ----------------------------------------------------------------------------
module bzf_div
	import bzf_pkg::*;
#(
	parameter int NW = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [NW-1:0]  divisor,
	output logic           done,
	output logic [T_W-1:0] quo,
	output logic [NW-1:0]  rem
);

	logic           busy_q;
	logic           done_q;
	logic [4:0]     cnt_q;
	logic [NW-1:0]  d_q;
	logic [NW-1:0]  rem_q;
	logic [T_W-1:0] quo_q;
	logic           bit_in;
	logic [NW:0]    trial;
	logic [NW:0]    diff;
	logic           ge;

	assign bit_in = (cnt_q == 5'(T_W - 1));
	assign trial  = {rem_q, bit_in};
	assign ge     = (trial >= {1'b0, d_q});
	assign diff   = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			d_q    <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(T_W - 1);
				d_q    <= divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
				quo_q <= {quo_q[T_W-2:0], ge};
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/bzf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzf_mac: shared two-stage multiply-accumulate unit
// Multiplies a 16-bit operand chunk by a 17-bit weight, registers the
// product, then adds it, shifted by whole chunks, into a 64-bit accumulator.
// ----------------------------------------------------------------------------
module bzf_mac
	import bzf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mac_op_t          op,
	output logic [ACC_W-1:0] acc
);

	localparam int PROD_W = CHUNK_W + WGT_W;

	logic              vld_s1;
	logic              clr_s1;
	logic [1:0]        shift_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0]  addend;
	logic [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			clr_s1   <= 1'b0;
			shift_s1 <= '0;
			prod_s1  <= '0;
			acc_q    <= '0;
		end else begin
			vld_s1   <= op.vld;
			clr_s1   <= op.clr;
			shift_s1 <= op.shift;
			prod_s1  <= PROD_W'(op.chunk) * PROD_W'(op.wgt);
			if (vld_s1) begin
				acc_q <= (clr_s1 ? '0 : acc_q) + addend;
			end
		end
	end

	always_comb begin
		unique case (shift_s1)
			2'd0:    addend = ACC_W'(prod_s1);
			2'd1:    addend = ACC_W'(prod_s1) << CHUNK_W;
			2'd2:    addend = ACC_W'(prod_s1) << (2 * CHUNK_W);
			default: addend = '0;
		endcase
	end

	assign acc = acc_q;

endmodule

FILE: hdl/bzf_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzf_eval: point evaluator sequencer
// Runs exact integer de Casteljau on both axes through the shared
// multiply-accumulate unit and rounds each axis to Q12.4 with saturation.
// ----------------------------------------------------------------------------
module bzf_eval
	import bzf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [T_W-1:0] t,
	input  axis_pts_t      bx,
	input  axis_pts_t      by,
	output logic           done,
	output point_t         pt
);

	typedef enum logic [1:0] {E_IDLE, E_ISSUE, E_DRAIN, E_STORE} state_t;
	typedef enum logic [1:0] {LV_B, LV_A, LV_C} lvl_t;

	state_t           state_q;
	lvl_t             lv_q;
	logic             axis_q;
	logic [1:0]       idx_q;
	logic             term_q;
	logic [1:0]       chunk_q;
	logic [T_W-1:0]   t_q;
	logic [T_W-1:0]   u_q;
	logic [31:0]      a_q [3];
	logic [47:0]      c_q [2];
	logic             done_q;
	point_t           pt_q;
	logic [1:0]       sel;
	logic [1:0]       last_idx;
	logic [31:0]      a_src;
	logic [47:0]      c_src;
	axis_pts_t        pts;
	mac_op_t          op;
	logic [ACC_W-1:0] acc;

	function automatic logic signed [15:0] round_q48(input logic [ACC_W-1:0] s);
		logic [ACC_W:0] sum;
		logic [16:0]    v;
		sum = {1'b0, s} + ((ACC_W + 1)'(1) << 47);
		v   = sum[ACC_W:48];
		if (v[16]) begin
			round_q48 = 16'sh7FFF;
		end else begin
			round_q48 = {~v[15], v[14:0]};
		end
	endfunction

	assign sel      = idx_q + {1'b0, term_q};
	assign last_idx = 2'd2 - lv_q;
	assign pts      = axis_q ? by : bx;

	always_comb begin
		unique case (sel)
			2'd0:    a_src = a_q[0];
			2'd1:    a_src = a_q[1];
			2'd2:    a_src = a_q[2];
			default: a_src = a_q[0];
		endcase
		c_src = c_q[sel[0]];

		op.vld   = (state_q == E_ISSUE);
		op.clr   = !term_q && (chunk_q == 2'd0);
		op.shift = chunk_q;
		op.wgt   = term_q ? t_q : u_q;
		unique case (lv_q)
			LV_B:    op.chunk = pts[sel];
			LV_A:    op.chunk = chunk_q[0] ? a_src[31:16] : a_src[15:0];
			LV_C: begin
				unique case (chunk_q)
					2'd0:    op.chunk = c_src[15:0];
					2'd1:    op.chunk = c_src[31:16];
					2'd2:    op.chunk = c_src[47:32];
					default: op.chunk = '0;
				endcase
			end
			default: op.chunk = '0;
		endcase
	end

	bzf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			lv_q    <= LV_B;
			axis_q  <= 1'b0;
			idx_q   <= '0;
			term_q  <= 1'b0;
			chunk_q <= '0;
			t_q     <= '0;
			u_q     <= '0;
			a_q     <= '{default: '0};
			c_q     <= '{default: '0};
			done_q  <= 1'b0;
			pt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						t_q     <= t;
						u_q     <= T_ONE - t;
						axis_q  <= 1'b0;
						lv_q    <= LV_B;
						idx_q   <= '0;
						term_q  <= 1'b0;
						chunk_q <= '0;
						state_q <= E_ISSUE;
					end
				end
				E_ISSUE: begin
					if (chunk_q == lv_q) begin
						chunk_q <= '0;
						if (term_q) begin
							term_q  <= 1'b0;
							state_q <= E_DRAIN;
						end else begin
							term_q <= 1'b1;
						end
					end else begin
						chunk_q <= chunk_q + 2'd1;
					end
				end
				E_DRAIN: begin
					state_q <= E_STORE;
				end
				E_STORE: begin
					unique case (lv_q)
						LV_B: begin
							unique case (idx_q)
								2'd0:    a_q[0] <= acc[31:0];
								2'd1:    a_q[1] <= acc[31:0];
								2'd2:    a_q[2] <= acc[31:0];
								default: a_q[0] <= a_q[0];
							endcase
						end
						LV_A: c_q[idx_q[0]] <= acc[47:0];
						LV_C: begin
							if (axis_q) begin
								pt_q.y <= round_q48(acc);
							end else begin
								pt_q.x <= round_q48(acc);
							end
						end
						default: pt_q <= pt_q;
					endcase
					if (idx_q == last_idx) begin
						idx_q <= '0;
						unique case (lv_q)
							LV_B: begin
								lv_q    <= LV_A;
								state_q <= E_ISSUE;
							end
							LV_A: begin
								lv_q    <= LV_C;
								state_q <= E_ISSUE;
							end
							LV_C: begin
								lv_q <= LV_B;
								if (axis_q) begin
									done_q  <= 1'b1;
									state_q <= E_IDLE;
								end else begin
									axis_q  <= 1'b1;
									state_q <= E_ISSUE;
								end
							end
							default: state_q <= E_IDLE;
						endcase
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= E_ISSUE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign pt   = pt_q;

	a_chunk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_ISSUE |-> chunk_q <= lv_q)
		else $error("chunk counter ran past the operand width of its level");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_ISSUE |-> idx_q <= last_idx)
		else $error("operation index ran past the last operation of its level");

	a_done_after_y: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == E_IDLE && axis_q)
		else $error("point reported before the y axis was finished");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == E_IDLE)
		else $error("evaluator started while busy");

endmodule

FILE: hdl/cubic_bezier_flattener_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_core: cubic Bezier curve flattener
// Splits one curve into N line segments at t = k/N, evaluated exactly in
// fixed point through one shared multiply-accumulate unit.
//
//   Channel  Handshake                         Payload
//   in       in_valid / in_ready               p0_x .. p3_y, color_rgba
//   out      out_valid / out_ready             start/end x,y, color, last
//   config   segment_count_we                  segment_count_wdata
//
// A curve first runs the divider for the Q1.16 step, then evaluates N+1
// points, each bounded by the shared multiplier: per axis 20
// multiply-accumulate issues, with a drain and a store state after each of
// the six de Casteljau operations. in_ready is high only between curves.
// Reset clears the control state and sets the segment count to 5. A stalled
// output holds the next segment back and pauses evaluation until the output
// register frees up.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_core
	import bzf_pkg::*;
#(
	parameter int MAX_SEGMENTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               segment_count_we,
	input  logic [5:0]         segment_count_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] p0_x,
	input  logic signed [15:0] p0_y,
	input  logic signed [15:0] p1_x,
	input  logic signed [15:0] p1_y,
	input  logic signed [15:0] p2_x,
	input  logic signed [15:0] p2_y,
	input  logic signed [15:0] p3_x,
	input  logic signed [15:0] p3_y,
	input  logic [31:0]        color_rgba,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] start_x,
	output logic signed [15:0] start_y,
	output logic signed [15:0] end_x,
	output logic signed [15:0] end_y,
	output logic [31:0]        segment_color,
	output logic               last_segment
);

	localparam int         NW    = $clog2(MAX_SEGMENTS + 1);
	localparam logic [6:0] MAX_W = 7'(MAX_SEGMENTS);

	typedef enum logic [2:0] {T_IDLE, T_DIV, T_LAUNCH, T_EVAL, T_PUSH} state_t;

	state_t         state_q;
	logic [5:0]     cfg_q;
	axis_pts_t      bx_q;
	axis_pts_t      by_q;
	logic [31:0]    color_q;
	logic [NW-1:0]  n_q;
	logic [NW-1:0]  k_q;
	logic [T_W-1:0] t_q;
	logic [NW-1:0]  racc_q;
	point_t         prev_q;
	logic           out_valid_q;
	point_t         seg_start_q;
	point_t         seg_end_q;
	logic [31:0]    seg_color_q;
	logic           seg_last_q;

	logic           accept;
	logic [NW-1:0]  n_calc;
	logic           div_done;
	logic [T_W-1:0] div_quo;
	logic [NW-1:0]  div_rem;
	logic [NW:0]    sum_r;
	logic           carry;
	logic [NW-1:0]  racc_next;
	logic [T_W-1:0] t_next;
	logic           eval_start;
	logic           eval_done;
	point_t         eval_pt;
	logic           slot_free;

	assign in_ready   = (state_q == T_IDLE);
	assign accept     = in_valid && in_ready;
	assign eval_start = (state_q == T_LAUNCH);
	assign slot_free  = !out_valid_q || out_ready;

	always_comb begin
		if (cfg_q == 6'd0) begin
			n_calc = NW'(1);
		end else if ({1'b0, cfg_q} > MAX_W) begin
			n_calc = NW'(MAX_W);
		end else begin
			n_calc = NW'({1'b0, cfg_q});
		end
	end

	assign sum_r     = {1'b0, racc_q} + {1'b0, div_rem};
	assign carry     = (sum_r >= {1'b0, n_q});
	assign racc_next = carry ? NW'(sum_r - {1'b0, n_q}) : sum_r[NW-1:0];
	assign t_next    = t_q + div_quo + T_W'(carry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 6'd5;
		end else if (segment_count_we) begin
			cfg_q <= segment_count_wdata;
		end
	end

	bzf_div #(
		.NW (NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.divisor (n_calc),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	bzf_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eval_start),
		.t      (t_q),
		.bx     (bx_q),
		.by     (by_q),
		.done   (eval_done),
		.pt     (eval_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			bx_q        <= '0;
			by_q        <= '0;
			color_q     <= '0;
			n_q         <= NW'(1);
			k_q         <= '0;
			t_q         <= '0;
			racc_q      <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			seg_start_q <= '0;
			seg_end_q   <= '0;
			seg_color_q <= '0;
			seg_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						bx_q    <= {{~p3_x[15], p3_x[14:0]}, {~p2_x[15], p2_x[14:0]},
						            {~p1_x[15], p1_x[14:0]}, {~p0_x[15], p0_x[14:0]}};
						by_q    <= {{~p3_y[15], p3_y[14:0]}, {~p2_y[15], p2_y[14:0]},
						            {~p1_y[15], p1_y[14:0]}, {~p0_y[15], p0_y[14:0]}};
						color_q <= color_rgba;
						n_q     <= n_calc;
						k_q     <= '0;
						state_q <= T_DIV;
					end
				end
				T_DIV: begin
					if (div_done) begin
						t_q     <= '0;
						racc_q  <= '0;
						k_q     <= '0;
						state_q <= T_LAUNCH;
					end
				end
				T_LAUNCH: begin
					state_q <= T_EVAL;
				end
				T_EVAL: begin
					if (eval_done) begin
						state_q <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (k_q == '0) begin
						prev_q  <= eval_pt;
						k_q     <= k_q + NW'(1);
						t_q     <= t_next;
						racc_q  <= racc_next;
						state_q <= T_LAUNCH;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						seg_start_q <= prev_q;
						seg_end_q   <= eval_pt;
						seg_color_q <= color_q;
						seg_last_q  <= (k_q == n_q);
						prev_q      <= eval_pt;
						if (k_q == n_q) begin
							state_q <= T_IDLE;
						end else begin
							k_q     <= k_q + NW'(1);
							t_q     <= t_next;
							racc_q  <= racc_next;
							state_q <= T_LAUNCH;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign start_x       = seg_start_q.x;
	assign start_y       = seg_start_q.y;
	assign end_x         = seg_end_q.x;
	assign end_y         = seg_end_q.y;
	assign segment_color = seg_color_q;
	assign last_segment  = seg_last_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("block still ready after taking a curve");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != T_IDLE |-> n_q != '0 && k_q <= n_q)
		else $error("segment counter outside the curve's segment count");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == T_DIV)
		else $error("divider finished outside of its wait state");

	a_eval_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		eval_done |-> state_q == T_EVAL)
		else $error("evaluator finished outside of its wait state");

endmodule
